// ===== hdl/bfrc_pkg.sv =====
// bfrc_pkg: shared types and constants of the flip and range count tree
// payload structs, controller state enum and the controller/datapath command and status structs
// no dependencies
`default_nettype none

package bfrc_pkg;

	localparam int unsigned POS_W      = 10;
	localparam int unsigned CNT_W      = 10;
	localparam int unsigned LEAVES_DEF = 1024;

	localparam logic ACT_FLIP  = 1'b0;
	localparam logic ACT_COUNT = 1'b1;

	typedef struct packed {
		logic             action;
		logic [POS_W-1:0] first_position;
		logic [POS_W-1:0] last_position;
	} req_t;

	typedef struct packed {
		logic [CNT_W-1:0] set_count;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_FLIP_RD,
		ST_FLIP_LEAF,
		ST_FLIP_UP,
		ST_WALK,
		ST_ADD,
		ST_OUT
	} st_t;

	typedef struct packed {
		logic accept;
		logic clr_wr;
		logic flip_rd;
		logic flip_wr;
		logic flip_first;
		logic walk;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clr_last;
		logic is_count;
		logic flip_ok;
		logic count_ok;
		logic meet;
		logic at_root;
		logic out_room;
	} stat_t;

endpackage

`default_nettype wire

// ===== hdl/bfrc_req_if.sv =====
// bfrc_req_if: request channel, valid/ready handshake with a req_t payload
// depends on bfrc_pkg
`default_nettype none

interface bfrc_req_if import bfrc_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bfrc_rsp_if.sv =====
// bfrc_rsp_if: result channel, valid/ready handshake with a rsp_t payload
// depends on bfrc_pkg
`default_nettype none

interface bfrc_rsp_if import bfrc_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== hdl/bit_flip_range_count_tree.sv =====
// bit_flip_range_count_tree: top level, flag row with toggle and inclusive range count
// instantiates bfrc_ctrl and bfrc_path; depends on bfrc_pkg, bfrc_req_if, bfrc_rsp_if
//
// usage
//  req channel carries action, first_position, last_position; a transfer with
//  action flip toggles the flag at first_position and gives no result, a
//  transfer with action count gives one rsp transfer holding set_count, the
//  number of set flags from first_position to last_position inclusive
//  flags live at positions 1 to LEAVES-2; a bad flip is dropped, a bad count gives 0
//  counts sit in a 2*LEAVES entry tree memory, one level handled per cycle
//  flip: next transfer taken once the read-modify-write chain from leaf to root
//   has run on the one write port
//  count: the walk handles one level per cycle on the two read ports, then the
//   result is loaded; the next transfer is taken in the cycle after the load
//  after reset a clearing pass zeros the memory with ready low
//  results wait in an output register; the next request is taken while a result
//   waits, and a count that finishes while the register is still full holds
//   until the receiver takes the waiting transfer
`default_nettype none

module bit_flip_range_count_tree import bfrc_pkg::*; #(
	parameter int unsigned LEAVES = LEAVES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	bfrc_req_if.sink   req,
	bfrc_rsp_if.source rsp
);

	cmd_t  cmd;
	stat_t stat;
	logic  in_ready;

	assign req.ready = in_ready;

	// sequencing: clear, flip chain, count walk, result load
	bfrc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (req.valid),
		.in_ready (in_ready),
		.stat     (stat),
		.cmd      (cmd)
	);

	// tree memory, walk registers and output register
	bfrc_path #(
		.LEAVES (LEAVES)
	) u_path (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_data (req.data),
		.cmd      (cmd),
		.stat     (stat),
		.rsp      (rsp)
	);

endmodule

`default_nettype wire

// ===== hdl/bfrc_ctrl.sv =====
// bfrc_ctrl: controller state machine of the flip and range count tree
// sequences clearing, flip updates and count walks; depends on bfrc_pkg
`default_nettype none

module bfrc_ctrl import bfrc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  stat_t stat,
	output cmd_t  cmd
);

	st_t state_q;
	st_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clr_wr = 1'b1;
				if (stat.clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (stat.is_count) begin
						state_d = stat.count_ok ? ST_WALK : ST_OUT;
					end else if (stat.flip_ok) begin
						state_d = ST_FLIP_RD;
					end
				end
			end
			ST_FLIP_RD: begin
				cmd.flip_rd = 1'b1;
				state_d     = ST_FLIP_LEAF;
			end
			ST_FLIP_LEAF: begin
				cmd.flip_wr    = 1'b1;
				cmd.flip_first = 1'b1;
				state_d        = ST_FLIP_UP;
			end
			ST_FLIP_UP: begin
				cmd.flip_wr = 1'b1;
				if (stat.at_root) begin
					state_d = ST_IDLE;
				end
			end
			ST_WALK: begin
				cmd.walk = 1'b1;
				if (stat.meet) begin
					state_d = ST_ADD;
				end
			end
			ST_ADD: begin
				state_d = ST_OUT;
			end
			ST_OUT: begin
				if (stat.out_room) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

// ===== hdl/bfrc_path.sv =====
// bfrc_path: datapath of the flip and range count tree
// node count memory, walk registers, accumulator and result register; depends on bfrc_pkg, bfrc_rsp_if
`default_nettype none

module bfrc_path import bfrc_pkg::*; #(
	parameter int unsigned LEAVES = LEAVES_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  req_t       req_data,
	input  cmd_t       cmd,
	output stat_t      stat,
	bfrc_rsp_if.source rsp
);

	localparam int unsigned NODES    = 2 * LEAVES;
	localparam int unsigned NODE_AW  = $clog2(NODES);
	localparam int unsigned LAST_POS = LEAVES - 2;
	localparam logic [NODE_AW-1:0] LEAF_BASE = NODE_AW'(LEAVES);
	localparam logic [NODE_AW-1:0] ONE_NODE  = NODE_AW'(1);

	logic [CNT_W-1:0]   mem [NODES];
	logic [CNT_W-1:0]   rd_a_q;
	logic [CNT_W-1:0]   rd_b_q;
	logic [NODE_AW-1:0] addr_a;
	logic [NODE_AW-1:0] addr_b;
	logic [NODE_AW-1:0] wr_addr;
	logic [CNT_W-1:0]   wr_data;
	logic               wr_en;

	logic [NODE_AW-1:0] clr_q;
	logic [NODE_AW-1:0] node_q;
	logic [NODE_AW-1:0] left_q;
	logic [NODE_AW-1:0] right_q;
	logic               dec_q;
	logic               dec;
	logic               take_a_s1;
	logic               take_b_s1;
	logic [CNT_W-1:0]   acc_q;
	logic [CNT_W-1:0]   add_a;
	logic [CNT_W-1:0]   add_b;
	logic               out_valid_q;
	logic [CNT_W-1:0]   set_count_q;

	logic [31:0]        first_w;
	logic [31:0]        last_w;
	logic [NODE_AW-1:0] first_n;
	logic [NODE_AW-1:0] last_n;

	// input checks
	assign first_w = 32'(req_data.first_position);
	assign last_w  = 32'(req_data.last_position);
	assign first_n = NODE_AW'(req_data.first_position);
	assign last_n  = NODE_AW'(req_data.last_position);

	assign stat.is_count = (req_data.action == ACT_COUNT);
	assign stat.flip_ok  = (first_w != 32'd0) && (first_w <= LAST_POS);
	assign stat.count_ok = (first_w != 32'd0) && (last_w <= LAST_POS) && (first_w <= last_w);
	assign stat.meet     = (left_q[NODE_AW-1:1] == right_q[NODE_AW-1:1]);
	assign stat.at_root  = (node_q == ONE_NODE);
	assign stat.clr_last = &clr_q;
	assign stat.out_room = !out_valid_q || rsp.ready;

	// memory ports
	always_comb begin
		if (cmd.walk) begin
			addr_a = {left_q[NODE_AW-1:1], 1'b1};
		end else if (cmd.flip_rd) begin
			addr_a = node_q;
		end else begin
			addr_a = node_q >> 1;
		end
	end
	assign addr_b = {right_q[NODE_AW-1:1], 1'b0};

	assign dec     = cmd.flip_first ? (rd_a_q == CNT_W'(1)) : dec_q;
	assign wr_en   = cmd.clr_wr || cmd.flip_wr;
	assign wr_addr = cmd.clr_wr ? clr_q : node_q;
	always_comb begin
		if (cmd.clr_wr) begin
			wr_data = '0;
		end else if (dec) begin
			wr_data = rd_a_q - CNT_W'(1);
		end else begin
			wr_data = rd_a_q + CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_a_q <= mem[addr_a];
		rd_b_q <= mem[addr_b];
	end

	// walk and flip registers
	assign add_a = take_a_s1 ? rd_a_q : '0;
	assign add_b = take_b_s1 ? rd_b_q : '0;

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			node_q  <= LEAF_BASE + first_n;
			left_q  <= LEAF_BASE + first_n - ONE_NODE;
			right_q <= LEAF_BASE + last_n + ONE_NODE;
		end else begin
			if (cmd.flip_wr) begin
				node_q <= node_q >> 1;
			end
			if (cmd.walk) begin
				left_q  <= left_q >> 1;
				right_q <= right_q >> 1;
			end
		end
		if (cmd.flip_first) begin
			dec_q <= dec;
		end
		if (cmd.out_load) begin
			set_count_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q       <= '0;
			take_a_s1   <= 1'b0;
			take_b_s1   <= 1'b0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.clr_wr) begin
				clr_q <= clr_q + ONE_NODE;
			end
			take_a_s1 <= cmd.walk && !stat.meet && !left_q[0];
			take_b_s1 <= cmd.walk && !stat.meet && right_q[0];
			acc_q     <= cmd.accept ? '0 : acc_q + add_a + add_b;
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.data.set_count = set_count_q;

	// a leaf only ever holds zero or one
	a_leaf_bit: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flip_first |-> (rd_a_q == CNT_W'(0)) || (rd_a_q == CNT_W'(1)))
		else $error("leaf count not 0 or 1");

	// flip update never walks above the root
	a_flip_node: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.flip_wr |-> (node_q != '0))
		else $error("flip update at node 0");

	// open interval stays ordered during the walk
	a_walk_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.walk |-> (left_q < right_q))
		else $error("walk bounds crossed");

	// a finished count reaches the result register only after its last add
	a_load_after_add: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> !take_a_s1 && !take_b_s1)
		else $error("result loaded with reads pending");

endmodule

`default_nettype wire
